// ===== design/ale_pkg.sv =====
// ============================================================================
// ale_pkg
// Shared types and constants of the associated Legendre evaluator: field
// widths, sequencing counts, state, command and status types.
// ============================================================================
package ale_pkg;

    // Field widths of the channel payloads.
    localparam int LVL_W  = 4;   // degree and order fields
    localparam int X_W    = 32;  // argument field
    localparam int VAL_W  = 64;  // result field

    // Small integer factors such as 2l-1 or l+m-1 stay below 32 for any
    // level that a 4-bit field can carry.
    localparam int FACT_W = 5;

    // Sequencing counts.
    localparam int SQRT_STEPS = 32;              // one result bit per cycle
    localparam int PP_STEPS   = 4;               // 32x32 partial products
    localparam int DIV_BITS   = 8;               // quotient bits per cycle
    localparam int DIV_STEPS  = VAL_W / DIV_BITS;
    localparam int CNT_W      = 5;               // holds SQRT_STEPS-1

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_SQ_INIT,
        ST_SQ_STEP,
        ST_SQ_FIN,
        ST_MUL_LD,
        ST_MUL_PP,
        ST_MUL_RND,
        ST_MUL_FIN,
        ST_SUB,
        ST_DIV_LD,
        ST_DIV_STEP,
        ST_DIV_FIN,
        ST_WRITE
    } ale_state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_SQ_INIT,
        OP_SQ_STEP,
        OP_SQ_FIN,
        OP_MUL_LOAD,
        OP_MUL_PP,
        OP_MUL_RND,
        OP_MUL_FIN,
        OP_SUB,
        OP_DIV_LOAD,
        OP_DIV_STEP,
        OP_DIV_FIN,
        OP_WRITE
    } ale_op_t;

    // Which product the shared multiplier is forming.
    typedef enum logic [1:0] {
        JOB_PMM,    // P(m,m) times -(2i-1)s
        JOB_P1,     // (2m+1)x times P(m,m)
        JOB_A,      // (2l-1)x times P(l-1,m)
        JOB_B       // (l+m-1) times P(l-2,m), no rounding shift
    } ale_job_t;

    typedef enum logic [1:0] {
        SEL_ZERO,
        SEL_PMM,
        SEL_PMMP1
    } ale_sel_t;

    typedef struct packed {
        ale_op_t             op;
        ale_job_t            job;
        logic [FACT_W-1:0]   k;
        logic [LVL_W-1:0]    div;
        logic [1:0]          pp;
        ale_sel_t            out_sel;
    } ale_cmd_t;

    typedef struct packed {
        logic out_free;
    } ale_status_t;

endpackage

// ===== design/ale_in_if.sv =====
// ============================================================================
// ale_in_if
// Request channel: degree, order and argument of one item.
// ============================================================================
interface ale_in_if
    import ale_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [LVL_W-1:0]        degree;
    logic [LVL_W-1:0]        order;
    logic signed [X_W-1:0]   arg_x;

    modport source (output valid, output degree, output order, output arg_x,
                    input ready);
    modport sink   (input valid, input degree, input order, input arg_x,
                    output ready);
endinterface

// ===== design/ale_out_if.sv =====
// ============================================================================
// ale_out_if
// Result channel: one polynomial value per item.
// ============================================================================
interface ale_out_if
    import ale_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] poly_value;

    modport source (output valid, output poly_value, input ready);
    modport sink   (input valid, input poly_value, output ready);
endinterface

// ===== design/ale_ctrl.sv =====
// ============================================================================
// ale_ctrl
// Sequencer of the evaluator: walks the square root, the P(m,m) product
// chain and the degree recurrence, and issues one command per cycle.
// ============================================================================
module ale_ctrl
    import ale_pkg::*;
#(
    parameter int MAX_DEGREE = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             args_valid,
    output logic             args_ready,
    input  logic [LVL_W-1:0] degree,
    input  logic [LVL_W-1:0] order,
    input  ale_status_t      status,
    output ale_cmd_t         cmd
);

    localparam logic [LVL_W-1:0] MAX_LVL = LVL_W'(MAX_DEGREE);

    ale_state_t          state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [LVL_W-1:0]    l_reg, l_next;
    logic [LVL_W-1:0]    m_reg, m_next;
    logic [LVL_W-1:0]    i_reg, i_next;
    logic [LVL_W-1:0]    ll_reg, ll_next;
    logic [FACT_W-1:0]   k_reg, k_next;
    ale_job_t            job_reg, job_next;
    logic                zero_reg, zero_next;
    ale_sel_t            sel_reg, sel_next;

    logic [LVL_W-1:0]    l_sat;
    logic                l_is_m;
    logic                l_is_m1;

    assign l_sat   = (degree > MAX_LVL) ? MAX_LVL : degree;
    assign l_is_m  = (l_reg == m_reg);
    assign l_is_m1 = ({1'b0, l_reg} == ({1'b0, m_reg} + 5'd1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            l_reg     <= '0;
            m_reg     <= '0;
            i_reg     <= '0;
            ll_reg    <= '0;
            k_reg     <= '0;
            job_reg   <= JOB_PMM;
            zero_reg  <= 1'b0;
            sel_reg   <= SEL_ZERO;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            l_reg     <= l_next;
            m_reg     <= m_next;
            i_reg     <= i_next;
            ll_reg    <= ll_next;
            k_reg     <= k_next;
            job_reg   <= job_next;
            zero_reg  <= zero_next;
            sel_reg   <= sel_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        l_next      = l_reg;
        m_next      = m_reg;
        i_next      = i_reg;
        ll_next     = ll_reg;
        k_next      = k_reg;
        job_next    = job_reg;
        zero_next   = zero_reg;
        sel_next    = sel_reg;
        args_ready  = 1'b0;
        cmd.op      = OP_NONE;
        cmd.job     = job_reg;
        cmd.k       = k_reg;
        cmd.div     = ll_reg - m_reg;
        cmd.pp      = cnt_reg[1:0];
        cmd.out_sel = sel_reg;

        case (state_reg)
            ST_IDLE:
            begin
                args_ready = 1'b1;
                if (args_valid)
                begin
                    cmd.op     = OP_LOAD;
                    l_next     = l_sat;
                    m_next     = order;
                    zero_next  = (order > l_sat);
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                if (zero_reg)
                begin
                    sel_next   = SEL_ZERO;
                    state_next = ST_WRITE;
                end
                else if (m_reg == '0)
                begin
                    // P(m,m) is exactly one, no square root is needed.
                    if (l_is_m)
                    begin
                        sel_next   = SEL_PMM;
                        state_next = ST_WRITE;
                    end
                    else
                    begin
                        job_next   = JOB_P1;
                        k_next     = {m_reg, 1'b1};
                        state_next = ST_MUL_LD;
                    end
                end
                else
                begin
                    state_next = ST_SQ_INIT;
                end
            end
            ST_SQ_INIT:
            begin
                cmd.op     = OP_SQ_INIT;
                cnt_next   = '0;
                state_next = ST_SQ_STEP;
            end
            ST_SQ_STEP:
            begin
                cmd.op = OP_SQ_STEP;
                if (cnt_reg == CNT_W'(SQRT_STEPS - 1))
                begin
                    state_next = ST_SQ_FIN;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_SQ_FIN:
            begin
                cmd.op     = OP_SQ_FIN;
                i_next     = LVL_W'(1);
                k_next     = FACT_W'(1);
                job_next   = JOB_PMM;
                state_next = ST_MUL_LD;
            end
            ST_MUL_LD:
            begin
                cmd.op     = OP_MUL_LOAD;
                cnt_next   = '0;
                state_next = ST_MUL_PP;
            end
            ST_MUL_PP:
            begin
                cmd.op = OP_MUL_PP;
                if (cnt_reg == CNT_W'(PP_STEPS - 1))
                begin
                    state_next = ST_MUL_RND;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_MUL_RND:
            begin
                cmd.op     = OP_MUL_RND;
                state_next = ST_MUL_FIN;
            end
            ST_MUL_FIN:
            begin
                cmd.op = OP_MUL_FIN;
                case (job_reg)
                    JOB_PMM:
                    begin
                        if (i_reg == m_reg)
                        begin
                            if (l_is_m)
                            begin
                                sel_next   = SEL_PMM;
                                state_next = ST_WRITE;
                            end
                            else
                            begin
                                job_next   = JOB_P1;
                                k_next     = {m_reg, 1'b1};
                                state_next = ST_MUL_LD;
                            end
                        end
                        else
                        begin
                            // Next odd factor 2(i+1)-1.
                            i_next     = i_reg + 1'b1;
                            k_next     = {i_reg, 1'b1};
                            state_next = ST_MUL_LD;
                        end
                    end
                    JOB_P1:
                    begin
                        if (l_is_m1)
                        begin
                            sel_next   = SEL_PMMP1;
                            state_next = ST_WRITE;
                        end
                        else
                        begin
                            ll_next    = m_reg + LVL_W'(2);
                            k_next     = {m_reg, 1'b1} + FACT_W'(2);
                            job_next   = JOB_A;
                            state_next = ST_MUL_LD;
                        end
                    end
                    JOB_A:
                    begin
                        job_next   = JOB_B;
                        k_next     = FACT_W'({1'b0, ll_reg} + {1'b0, m_reg} - 5'd1);
                        state_next = ST_MUL_LD;
                    end
                    JOB_B:
                    begin
                        state_next = ST_SUB;
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_SUB:
            begin
                cmd.op     = OP_SUB;
                state_next = ST_DIV_LD;
            end
            ST_DIV_LD:
            begin
                cmd.op     = OP_DIV_LOAD;
                cnt_next   = '0;
                state_next = ST_DIV_STEP;
            end
            ST_DIV_STEP:
            begin
                cmd.op = OP_DIV_STEP;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = ST_DIV_FIN;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_DIV_FIN:
            begin
                cmd.op = OP_DIV_FIN;
                if (ll_reg == l_reg)
                begin
                    sel_next   = SEL_PMMP1;
                    state_next = ST_WRITE;
                end
                else
                begin
                    // Next degree ll+1 uses the factor 2(ll+1)-1.
                    ll_next    = ll_reg + 1'b1;
                    k_next     = {ll_reg, 1'b1};
                    job_next   = JOB_A;
                    state_next = ST_MUL_LD;
                end
            end
            ST_WRITE:
            begin
                if (status.out_free)
                begin
                    cmd.op     = OP_WRITE;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && args_valid) |=> (state_reg == ST_DISPATCH))
        else $error("accepted item did not move to dispatch");

    a_write_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_WRITE) |-> status.out_free)
        else $error("result written while output register is occupied");

    a_sqrt_length: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SQ_STEP && cnt_reg == CNT_W'(SQRT_STEPS - 1))
        |=> (state_reg == ST_SQ_FIN))
        else $error("square root did not finish after its last step");

    a_mul_start: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL_LD) |=> (state_reg == ST_MUL_PP && cnt_reg == '0))
        else $error("multiply did not start at its first partial product");
`endif

endmodule

// ===== design/ale_dpath.sv =====
// ============================================================================
// ale_dpath
// Arithmetic of the evaluator: a shared 32x32 multiplier with a 128-bit
// accumulator, a bit-serial square root, a radix-256 small divider, the
// recurrence registers and the output register.
// ============================================================================
module ale_dpath
    import ale_pkg::*;
#(
    parameter int FRAC_BITS = 30
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  ale_cmd_t                cmd,
    output ale_status_t             status,
    input  logic signed [X_W-1:0]   arg_x,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [VAL_W-1:0] poly_value
);

    localparam int XW = FRAC_BITS + 2;   // saturated x, signed
    localparam int MW = FRAC_BITS + 1;   // |x| and s, unsigned
    localparam int SPW = MW + FACT_W;    // small product

    localparam logic signed [X_W-1:0]   ONE_X   = 32'sd1 <<< FRAC_BITS;
    localparam logic signed [VAL_W-1:0] ONE_V   = 64'sd1 <<< FRAC_BITS;
    localparam logic [127:0]            RND_HALF = 128'd1 << (FRAC_BITS - 1);
    localparam logic [VAL_W-1:0]        POS_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic [VAL_W-1:0]        NEG_MAX = {1'b1, {(VAL_W-1){1'b0}}};

    // Recurrence and operand registers.
    logic signed [XW-1:0]    x_reg;
    logic [MW-1:0]           s_reg;
    logic signed [VAL_W-1:0] pmm_reg, pmmp1_reg, a_reg, b_reg, diff_reg;
    logic [VAL_W-1:0]        mag_a_reg, mag_b_reg;
    logic                    neg_reg;
    logic [127:0]            acc_reg;
    logic [VAL_W-1:0]        sq_rem_reg, sq_res_reg, sq_bit_reg;
    logic [VAL_W-1:0]        div_q_reg;
    logic [LVL_W-1:0]        div_r_reg;
    logic                    div_neg_reg;
    logic                    out_valid_reg;
    logic signed [VAL_W-1:0] out_value_reg;

    // Combinational helpers.
    logic signed [X_W-1:0]   x_sat;
    logic signed [X_W:0]     omx_s, opx_s;
    logic [MW-1:0]           x_abs;
    logic [31:0]             mul_a, mul_b;
    logic [63:0]             pp_prod;
    logic [6:0]              pp_shift;
    logic signed [VAL_W-1:0] first_op;
    logic [VAL_W-1:0]        first_u, first_mag;
    logic [MW-1:0]           small_src;
    logic                    sign_b;
    logic [SPW-1:0]          small_prod;
    logic [127:0]            q_full;
    logic [VAL_W-1:0]        q_mag;
    logic signed [VAL_W-1:0] mul_val;
    logic [VAL_W-1:0]        sq_trial;
    logic signed [VAL_W:0]   diff_w;
    logic signed [VAL_W-1:0] diff_sat;
    logic [VAL_W-1:0]        diff_u, diff_mag;
    logic [VAL_W-1:0]        dq;
    logic [LVL_W-1:0]        dr;
    logic [LVL_W:0]          dtrial;

    function automatic logic signed [VAL_W-1:0] from_mag(input logic neg,
                                                         input logic [VAL_W-1:0] mag);
        logic [VAL_W-1:0] lim;
        logic [VAL_W-1:0] m;
        lim = neg ? NEG_MAX : POS_MAX;
        m   = (mag > lim) ? lim : mag;
        return neg ? signed'(~m + 64'd1) : signed'(m);
    endfunction

    // Argument saturated to [-1, +1].
    assign x_sat = (arg_x > ONE_X) ? ONE_X : ((arg_x < -ONE_X) ? -ONE_X : arg_x);

    // 1-x and 1+x, both within [0, 2].
    assign omx_s = 33'(ONE_X) - 33'(x_reg);
    assign opx_s = 33'(ONE_X) + 33'(x_reg);
    assign x_abs = x_reg[XW-1] ? MW'(-x_reg) : MW'(x_reg);

    // Shared multiplier.
    always_comb
    begin
        if (cmd.op == OP_SQ_INIT)
        begin
            mul_a = omx_s[31:0];
            mul_b = opx_s[31:0];
        end
        else
        begin
            mul_a = cmd.pp[1] ? mag_a_reg[63:32] : mag_a_reg[31:0];
            mul_b = cmd.pp[0] ? mag_b_reg[63:32] : mag_b_reg[31:0];
        end
    end

    assign pp_prod  = 64'(mul_a) * 64'(mul_b);
    assign pp_shift = {({1'b0, cmd.pp[1]} + {1'b0, cmd.pp[0]}), 5'b0};

    // Operand selection for each product.
    always_comb
    begin
        case (cmd.job)
            JOB_PMM:
            begin
                first_op  = pmm_reg;
                small_src = s_reg;
                sign_b    = 1'b1;
            end
            JOB_P1:
            begin
                first_op  = pmm_reg;
                small_src = x_abs;
                sign_b    = x_reg[XW-1];
            end
            JOB_A:
            begin
                first_op  = pmmp1_reg;
                small_src = x_abs;
                sign_b    = x_reg[XW-1];
            end
            JOB_B:
            begin
                first_op  = pmm_reg;
                small_src = MW'(1);
                sign_b    = 1'b0;
            end
            default:
            begin
                first_op  = pmm_reg;
                small_src = '0;
                sign_b    = 1'b0;
            end
        endcase
    end

    assign first_u    = unsigned'(first_op);
    assign first_mag  = first_op[VAL_W-1] ? (~first_u + 64'd1) : first_u;
    assign small_prod = SPW'(small_src) * SPW'(cmd.k);

    // Product: scale (not for JOB_B), saturate the magnitude, apply the sign.
    assign q_full  = (cmd.job == JOB_B) ? acc_reg : (acc_reg >> FRAC_BITS);
    assign q_mag   = (|q_full[127:64]) ? '1 : q_full[63:0];
    assign mul_val = from_mag(neg_reg, q_mag);

    assign sq_trial = sq_res_reg + sq_bit_reg;

    // Saturating difference of the two recurrence terms.
    assign diff_w   = 65'(a_reg) - 65'(b_reg);
    assign diff_sat = (diff_w[VAL_W] != diff_w[VAL_W-1])
                      ? (diff_w[VAL_W] ? signed'(NEG_MAX) : signed'(POS_MAX))
                      : diff_w[VAL_W-1:0];
    assign diff_u   = unsigned'(diff_reg);
    assign diff_mag = diff_reg[VAL_W-1] ? (~diff_u + 64'd1) : diff_u;

    // Restoring division, DIV_BITS quotient bits per cycle.
    always_comb
    begin
        dq     = div_q_reg;
        dr     = div_r_reg;
        dtrial = '0;
        for (int j = 0; j < DIV_BITS; j++)
        begin
            dtrial = {dr, dq[VAL_W-1]};
            dq     = {dq[VAL_W-2:0], 1'b0};
            if (dtrial >= {1'b0, cmd.div})
            begin
                dtrial = dtrial - {1'b0, cmd.div};
                dq[0]  = 1'b1;
            end
            dr = dtrial[LVL_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                x_reg   <= XW'(x_sat);
                pmm_reg <= ONE_V;
            end
            OP_SQ_INIT:
            begin
                sq_rem_reg <= pp_prod;
                sq_res_reg <= '0;
                sq_bit_reg <= 64'd1 << 62;
            end
            OP_SQ_STEP:
            begin
                if (sq_rem_reg >= sq_trial)
                begin
                    sq_rem_reg <= sq_rem_reg - sq_trial;
                    sq_res_reg <= (sq_res_reg >> 1) + sq_bit_reg;
                end
                else
                begin
                    sq_res_reg <= sq_res_reg >> 1;
                end
                sq_bit_reg <= sq_bit_reg >> 2;
            end
            OP_SQ_FIN:
            begin
                s_reg <= MW'(sq_res_reg + 64'(sq_rem_reg > sq_res_reg));
            end
            OP_MUL_LOAD:
            begin
                mag_a_reg <= first_mag;
                mag_b_reg <= 64'(small_prod);
                neg_reg   <= first_op[VAL_W-1] ^ sign_b;
                acc_reg   <= '0;
            end
            OP_MUL_PP:
            begin
                acc_reg <= acc_reg + (128'(pp_prod) << pp_shift);
            end
            OP_MUL_RND:
            begin
                if (cmd.job != JOB_B)
                begin
                    acc_reg <= acc_reg + RND_HALF;
                end
            end
            OP_MUL_FIN:
            begin
                case (cmd.job)
                    JOB_PMM: pmm_reg   <= mul_val;
                    JOB_P1:  pmmp1_reg <= mul_val;
                    JOB_A:   a_reg     <= mul_val;
                    JOB_B:   b_reg     <= mul_val;
                    default: b_reg     <= mul_val;
                endcase
            end
            OP_SUB:
            begin
                diff_reg <= diff_sat;
            end
            OP_DIV_LOAD:
            begin
                div_q_reg   <= diff_mag + 64'(cmd.div >> 1);
                div_r_reg   <= '0;
                div_neg_reg <= diff_reg[VAL_W-1];
            end
            OP_DIV_STEP:
            begin
                div_q_reg <= dq;
                div_r_reg <= dr;
            end
            OP_DIV_FIN:
            begin
                pmm_reg   <= pmmp1_reg;
                pmmp1_reg <= from_mag(div_neg_reg, div_q_reg);
            end
            OP_WRITE:
            begin
                case (cmd.out_sel)
                    SEL_ZERO:  out_value_reg <= '0;
                    SEL_PMM:   out_value_reg <= pmm_reg;
                    SEL_PMMP1: out_value_reg <= pmmp1_reg;
                    default:   out_value_reg <= '0;
                endcase
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.op == OP_WRITE)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign status.out_free = !out_valid_reg || out_ready;
    assign out_valid       = out_valid_reg;
    assign poly_value      = out_value_reg;

endmodule

// ===== design/assoc_legendre_eval_core.sv =====
// ============================================================================
// assoc_legendre_eval_core - associated Legendre polynomial P(l,m,x)
// One item at a time; the next item is taken in the cycle after the result
// is written. An order above the degree goes straight to a zero result, and
// a zero order skips the square root. The 32-step square root, the shared
// multiplier and the divider set the run time of an item. Reset clears the
// sequencer and the output valid.
// ============================================================================
module assoc_legendre_eval_core
    import ale_pkg::*;
#(
    parameter int MAX_DEGREE = 8,
    parameter int FRAC_BITS  = 30
)
(
    input  logic  clk,
    input  logic  rst_n,
    ale_in_if.sink    args,
    ale_out_if.source result
);

    // The controller owns all sequencing: it accepts an item in its idle
    // state, saturates the degree, and then walks through three phases.
    // First the square root s = sqrt((1-x)(1+x)) is built one result bit per
    // cycle (skipped for zero order). Then P(m,m) is formed as a chain of m
    // products with -(2i-1)s, followed by P(m+1,m). Finally each degree step
    // forms two products, their saturating difference and a rounded divide by
    // (l-m). The datapath holds every value; the two modules talk only
    // through the command and status structs below.
    ale_cmd_t    cmd;
    ale_status_t status;

    ale_ctrl #(
        .MAX_DEGREE (MAX_DEGREE)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .args_valid (args.valid),
        .args_ready (args.ready),
        .degree     (args.degree),
        .order      (args.order),
        .status     (status),
        .cmd        (cmd)
    );

    // The output register in the datapath lets a finished result wait for
    // the consumer while the controller returns to idle and takes the next
    // item; a new result is only written once that register is free.
    ale_dpath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .arg_x      (args.arg_x),
        .out_valid  (result.valid),
        .out_ready  (result.ready),
        .poly_value (result.poly_value)
    );

endmodule

// ===== dv/assoc_legendre_eval_core_test.sv =====
// ============================================================================
// assoc_legendre_eval_core_test
// Self-checking testbench for the associated Legendre evaluator. A short
// directed set walks the corner cases: zero order, order above degree,
// degree past the limit, saturated argument and field extremes. A long
// random run follows. Both channels are throttled at random. Every result
// is checked against a fixed-point predictor of P(l,m,x) that runs in
// the testbench.
// ============================================================================
module assoc_legendre_eval_core_test;
    import ale_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_DEGREE = 8;
    localparam int FRAC_BITS  = 30;

    // The random part of the run sends this many items.
    localparam int RANDOM_ITEMS = 830;

    // The slowest item is l = 8, m = 1. The limit is the run time of that item
    // plus the longest receiver stall and the longest sender pause, taken
    // several times over.
    localparam int WATCHDOG_LIMIT = 2000;

    // Once the last result is in, wait longer than the slowest item takes so
    // that any extra result from the block would still show up.
    localparam int DRAIN_CYCLES = 250;

    // Mismatch lines beyond this count are counted but not printed.
    localparam int PRINT_LIMIT = 40;

    typedef logic signed [VAL_W-1:0] fx_t;

    localparam fx_t                  FX_ONE = 64'sd1 <<< FRAC_BITS;
    localparam logic signed [X_W-1:0] X_ONE  = 32'sd1 <<< FRAC_BITS;

    // One expected result, kept with the item that caused it so that a
    // mismatch line can say which item went wrong.
    typedef struct {
        logic [LVL_W-1:0]       degree;
        logic [LVL_W-1:0]       order;
        logic signed [X_W-1:0]  arg_x;
        fx_t                    value;
    } poly_expect_t;

    logic clk = 1'b0;
    logic rst_n;

    ale_in_if  args_ch ();
    ale_out_if result_ch ();

    assoc_legendre_eval_core #(
        .MAX_DEGREE (MAX_DEGREE),
        .FRAC_BITS  (FRAC_BITS)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .args   (args_ch),
        .result (result_ch)
    );

    poly_expect_t pending_values[$];

    int mismatch_count  = 0;
    int items_accepted  = 0;
    int results_checked = 0;
    int zero_cases      = 0;
    int clamped_degrees = 0;
    int saturated_args  = 0;
    int idle_cycles     = 0;
    int burst_left      = 0;

    // The clock has a 2 ns period.
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Fixed-point predictor
    // ------------------------------------------------------------------------

    // Magnitude of a signed value as an unsigned one. The most negative value
    // maps to 2^63, which still fits.
    function automatic logic [VAL_W-1:0] magnitude(fx_t v);
        return (v < 0) ? -v : v;
    endfunction

    // Gives back a signed value from a sign and a magnitude, clamped to the
    // signed 64-bit range.
    function automatic fx_t signed_clamp(logic neg, logic [VAL_W-1:0] mag);
        logic [VAL_W-1:0] lim;
        lim = neg ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
        if (mag > lim)
            mag = lim;
        return neg ? fx_t'(-mag) : fx_t'(mag);
    endfunction

    // Full 128-bit product of the magnitudes, shifted right by sh with
    // rounding to nearest and ties away from zero, then saturated.
    function automatic fx_t fixed_mul(fx_t a, fx_t b, int sh);
        logic                   neg;
        logic [2*VAL_W-1:0]     prod;
        logic [VAL_W-1:0]       q;
        neg  = (a < 0) != (b < 0);
        prod = {{VAL_W{1'b0}}, magnitude(a)} * {{VAL_W{1'b0}}, magnitude(b)};
        if (sh > 0)
            prod = (prod + ({{(2*VAL_W-1){1'b0}}, 1'b1} << (sh - 1))) >> sh;
        q = (prod[2*VAL_W-1:VAL_W] != '0) ? '1 : prod[VAL_W-1:0];
        return signed_clamp(neg, q);
    endfunction

    // Difference with saturation. A 65-bit difference whose top two bits
    // differ has left the 64-bit range.
    function automatic fx_t sat_diff(fx_t a, fx_t b);
        logic [VAL_W:0] d;
        d = {a[VAL_W-1], a} - {b[VAL_W-1], b};
        if (d[VAL_W] != d[VAL_W-1])
            return d[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
        return d[VAL_W-1:0];
    endfunction

    // Division by a small positive integer, rounded to nearest with ties
    // away from zero.
    function automatic fx_t round_div(fx_t n, int d);
        logic [VAL_W:0] q;
        q = ({1'b0, magnitude(n)} + (d / 2)) / d;
        return signed_clamp(n < 0, q[VAL_W-1:0]);
    endfunction

    // Integer square root, bit by bit, then rounded to nearest.
    function automatic logic [VAL_W-1:0] root_round(logic [VAL_W-1:0] t);
        logic [VAL_W-1:0] rem;
        logic [VAL_W-1:0] res;
        logic [VAL_W-1:0] bitv;
        rem  = t;
        res  = '0;
        bitv = 64'd1 << 62;
        while (bitv > t)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (rem >= res + bitv)
            begin
                rem = rem - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        if (t - res * res > res)
            res = res + 1;
        return res;
    endfunction

    // P(l,m,x) with the Condon-Shortley sign, as the block should give it.
    function automatic fx_t legendre_expect(logic [LVL_W-1:0] deg, logic [LVL_W-1:0] ord,
                                            logic signed [X_W-1:0] xin);
        int                 l;
        int                 m;
        int                 i;
        int                 k;
        fx_t                x;
        fx_t                s;
        fx_t                pmm;
        fx_t                pm1;
        fx_t                pk;
        logic [VAL_W-1:0]   t;
        l = (deg > MAX_DEGREE) ? MAX_DEGREE : int'(deg);
        m = ord;
        x = xin;
        if (x > FX_ONE)
            x = FX_ONE;
        if (x < -FX_ONE)
            x = -FX_ONE;
        if (m > l)
            return '0;

        pmm = FX_ONE;
        if (m > 0)
        begin
            t = (FX_ONE - x) * (FX_ONE + x);
            s = root_round(t);
            for (i = 1; i <= m; i++)
                pmm = fixed_mul(pmm, -(fx_t'(2 * i - 1) * s), FRAC_BITS);
        end
        if (l == m)
            return pmm;

        pm1 = fixed_mul(x * fx_t'(2 * m + 1), pmm, FRAC_BITS);
        if (l == m + 1)
            return pm1;

        pk = '0;
        for (k = m + 2; k <= l; k++)
        begin
            pk  = round_div(sat_diff(fixed_mul(x * fx_t'(2 * k - 1), pm1, FRAC_BITS),
                                     fixed_mul(fx_t'(k + m - 1), pmm, 0)),
                            k - m);
            pmm = pm1;
            pm1 = pk;
        end
        return pk;
    endfunction

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string msg);
        if (mismatch_count < PRINT_LIMIT)
            $display("MISMATCH at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // Everything is sampled at the rising edge, before the block updates.
    // The result side is handled first: a result leaving in the same cycle
    // as a new item is taken always belongs to an older item.
    always @(posedge clk)
    begin : result_check
        poly_expect_t exp_item;
        poly_expect_t new_item;
        if (rst_n)
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                if (pending_values.size() == 0)
                    report_mismatch($sformatf("result %0d with no item waiting",
                                              result_ch.poly_value));
                else
                begin
                    exp_item = pending_values.pop_front();
                    results_checked++;
                    if (result_ch.poly_value !== exp_item.value)
                        report_mismatch($sformatf(
                            "l=%0d m=%0d x=%0d: poly_value %0d, expected %0d",
                            exp_item.degree, exp_item.order, exp_item.arg_x,
                            result_ch.poly_value, exp_item.value));
                end
            end

            if (args_ch.valid && args_ch.ready)
            begin
                new_item.degree = args_ch.degree;
                new_item.order  = args_ch.order;
                new_item.arg_x  = args_ch.arg_x;
                new_item.value  = legendre_expect(args_ch.degree, args_ch.order,
                                                  args_ch.arg_x);
                pending_values.insert(pending_values.size(), new_item);
                items_accepted++;
                if (args_ch.degree > MAX_DEGREE)
                    clamped_degrees++;
                if (args_ch.order > ((args_ch.degree > MAX_DEGREE) ? MAX_DEGREE
                                                                   : args_ch.degree))
                    zero_cases++;
                if (args_ch.arg_x > X_ONE || args_ch.arg_x < -X_ONE)
                    saturated_args++;
            end
        end
    end

    // The watchdog counts cycles with no handshake on either side. A hang
    // anywhere ends the run.
    always @(posedge clk)
    begin
        if ((args_ch.valid && args_ch.ready) || (result_ch.valid && result_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog: no item moved for %0d cycles, %0d results still due",
                     WATCHDOG_LIMIT, pending_values.size());
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Receiver throttling
    // ------------------------------------------------------------------------

    // The receiver switches between several moods, each held for a random span:
    // always ready, coin flip, one cycle in four, and long stalls broken by
    // short ready windows. Because these spans run on their own, stalls land
    // on every phase of the block's sequencing.
    initial
    begin : result_throttle
        int  mood;
        int  span;
        int  tick;
        int  hold;
        logic level;
        result_ch.ready = 1'b0;
        tick  = 0;
        hold  = 0;
        level = 1'b0;
        @(posedge rst_n);
        forever
        begin
            mood = $urandom_range(0, 3);
            span = $urandom_range(50, 400);
            repeat (span)
            begin
                @(negedge clk);
                tick++;
                case (mood)
                    0: result_ch.ready <= 1'b1;
                    1: result_ch.ready <= 1'($urandom_range(0, 1));
                    2: result_ch.ready <= (tick % 4 == 0);
                    default:
                    begin
                        if (hold == 0)
                        begin
                            level = !level;
                            hold  = level ? $urandom_range(1, 10) : $urandom_range(1, 40);
                        end
                        hold--;
                        result_ch.ready <= level;
                    end
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // Item sender
    // ------------------------------------------------------------------------

    // Sends one item and waits until the block takes it. Items go out in
    // bursts. Between bursts the sender pauses for a random number of cycles
    // and puts junk on the fields while valid is low. Now and then a long
    // burst with no pause gives a stretch at full rate.
    task automatic send_item(input logic [LVL_W-1:0] deg, input logic [LVL_W-1:0] ord,
                             input logic signed [X_W-1:0] xv);
        int gap;
        @(negedge clk);
        args_ch.valid  <= 1'b1;
        args_ch.degree <= deg;
        args_ch.order  <= ord;
        args_ch.arg_x  <= xv;
        @(posedge clk);
        while (!args_ch.ready)
            @(posedge clk);
        burst_left--;
        if (burst_left <= 0)
        begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
            repeat (gap)
            begin
                @(negedge clk);
                args_ch.valid  <= 1'b0;
                args_ch.degree <= LVL_W'($urandom);
                args_ch.order  <= LVL_W'($urandom);
                args_ch.arg_x  <= $urandom;
            end
        end
    endtask

    // Random argument. Most values lie inside [-1, 1]. Some sit near the
    // ends, where s is small. Some are raw 32-bit patterns, so every bit
    // toggles and saturation gets hit. The rest are hand-picked points.
    function automatic logic signed [X_W-1:0] random_arg();
        logic signed [X_W-1:0] xv;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5, 6:
                xv = $urandom_range(0, 32'h8000_0000) - X_ONE;
            7:
            begin
                xv = X_ONE - $urandom_range(0, 1023);
                if ($urandom_range(0, 1))
                    xv = -xv;
            end
            8:
                xv = $urandom;
            default:
            begin
                case ($urandom_range(0, 7))
                    0: xv = '0;
                    1: xv = 32'sd1;
                    2: xv = -32'sd1;
                    3: xv = X_ONE;
                    4: xv = -X_ONE;
                    5: xv = X_ONE >>> 1;
                    6: xv = {1'b0, {(X_W-1){1'b1}}};
                    default: xv = {1'b1, {(X_W-1){1'b0}}};
                endcase
            end
        endcase
        return xv;
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // With zero order, P(m,m) is exactly one and no square root is formed.
    // The climb to the top degree is checked at both ends of the argument
    // range.
    task automatic test_zero_order();
        send_item(4'd0, 4'd0, '0);
        send_item(4'd8, 4'd0, X_ONE);
        send_item(4'd8, 4'd0, -X_ONE);
        send_item(4'd5, 4'd0, random_arg());
    endtask

    // An order above the degree must give exactly zero. This includes the
    // largest order that the field can carry.
    task automatic test_order_above_degree();
        send_item(4'd0, 4'd1, X_ONE >>> 1);
        send_item(4'd3, 4'd8, -X_ONE);
        send_item(4'd7, 4'd15, random_arg());
    endtask

    // A degree above the limit acts as the limit. The order test uses the
    // clamped degree, so order 9 with degree 12 is zero.
    task automatic test_degree_limit();
        send_item(4'd15, 4'd0, random_arg());
        send_item(4'd9, 4'd3, random_arg());
        send_item(4'd12, 4'd9, random_arg());
        send_item(4'd15, 4'd8, X_ONE >>> 2);
    endtask

    // An argument outside [-1, 1] is clamped first. The raw extremes and the
    // values just past one are all tried.
    task automatic test_argument_saturation();
        send_item(4'd4, 4'd2, {1'b0, {(X_W-1){1'b1}}});
        send_item(4'd4, 4'd2, {1'b1, {(X_W-1){1'b0}}});
        send_item(4'd6, 4'd1, X_ONE + 32'sd1);
        send_item(4'd6, 4'd1, -X_ONE - 32'sd1);
    endtask

    // Top order at the top degree gives the longest product chain. At x = 1
    // the square root is zero, and the smallest nonzero arguments are tried
    // too.
    task automatic test_field_extremes();
        send_item(4'd8, 4'd8, '0);
        send_item(4'd8, 4'd1, X_ONE);
        send_item(4'd8, 4'd8, 32'sd1);
        send_item(4'd1, 4'd1, -32'sd1);
        send_item(4'd1, 4'd0, 32'sd1);
        send_item(4'd8, 4'd7, random_arg());
    endtask

    // Most random items are well formed: a degree within the limit and an
    // order that does not exceed it, so the recurrence actually runs. The
    // rest use degrees past the limit or leave degree and order unconstrained.
    task automatic test_random_items();
        int                     n;
        int                     pick;
        logic [LVL_W-1:0]       deg;
        logic [LVL_W-1:0]       ord;
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            pick = $urandom_range(0, 19);
            if (pick < 15)
            begin
                deg = LVL_W'($urandom_range(0, MAX_DEGREE));
                ord = LVL_W'($urandom_range(0, deg));
            end
            else if (pick < 17)
            begin
                deg = LVL_W'($urandom_range(MAX_DEGREE + 1, 15));
                ord = LVL_W'($urandom_range(0, MAX_DEGREE + 2));
            end
            else
            begin
                deg = LVL_W'($urandom_range(0, 15));
                ord = LVL_W'($urandom_range(0, 15));
            end
            send_item(deg, ord, random_arg());
        end
    endtask

    // ------------------------------------------------------------------------
    // Run sequence
    // ------------------------------------------------------------------------

    initial
    begin
        rst_n          = 1'b0;
        args_ch.valid  = 1'b0;
        args_ch.degree = '0;
        args_ch.order  = '0;
        args_ch.arg_x  = '0;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_zero_order();
        test_order_above_degree();
        test_degree_limit();
        test_argument_saturation();
        test_field_extremes();
        test_random_items();

        @(negedge clk);
        args_ch.valid <= 1'b0;

        // Wait for every outstanding result. Then give the block time to
        // show any extra result.
        while (pending_values.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d items, checked %0d results, %0d mismatches.",
                 items_accepted, results_checked, mismatch_count);
        $display("Order above degree: %0d, degree past limit: %0d, argument clamped: %0d.",
                 zero_cases, clamped_degrees, saturated_args);
        if (mismatch_count == 0 && pending_values.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== files.f =====
design/ale_pkg.sv
design/ale_in_if.sv
design/ale_out_if.sv
design/ale_ctrl.sv
design/ale_dpath.sv
design/assoc_legendre_eval_core.sv
dv/assoc_legendre_eval_core_test.sv
